// ----- rtl/core/qph_pkg.sv -----
// ----------------------------------------------------------------------------
// qph_pkg
// shared types, codes and sizes of the quadratic probe hash table
// ----------------------------------------------------------------------------
package qph_pkg;

    localparam int SLOT_COUNT_DEF = 11;

    localparam int FUNC_W      = 1;
    localparam int KEY_W       = 63;
    localparam int VALUE_W     = 64;
    localparam int STATUS_W    = 2;
    localparam int SLOT_IDX_W  = 4;
    localparam int PROBE_W     = 4;

    // key reduction: padded key taken one byte per cycle
    localparam int HASH_W  = KEY_W + 1;
    localparam int DIGIT_W = 8;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 2'd0,
        STAT_FOUND     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } qph_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_ISSUE,
        ST_EVAL
    } qph_state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] entry_value;
    } qph_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [VALUE_W-1:0]    found_value;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [PROBE_W-1:0]    probe_count;
    } qph_out_t;

    typedef struct packed {
        logic        clear_step;
        logic        load_in;
        logic        hash_step;
        logic        issue;
        logic        write_slot;
        logic        load_result;
        qph_status_t result;
    } qph_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hash_last;
        logic used;
        logic match;
        logic exhausted;
        logic is_lookup;
    } qph_sts_t;

endpackage

// ----- rtl/core/qph_datapath.sv -----
// ----------------------------------------------------------------------------
// qph_datapath
// key reduction, probe address sequence, slot memory and result register
// ----------------------------------------------------------------------------
module qph_datapath import qph_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  qph_in_t  s_data,
    input  qph_cmd_t cmd,
    output qph_sts_t sts,
    output qph_out_t m_data
);

    localparam int SW     = $clog2(SLOT_COUNT);
    localparam int CW     = $clog2(SLOT_COUNT + 1);
    localparam int VW     = SW + DIGIT_W;
    localparam int DIGITS = HASH_W / DIGIT_W;
    localparam int DCW    = $clog2(DIGITS);
    localparam int MW     = 1 + KEY_W + VALUE_W;

    localparam logic [SW:0]   N_EXT     = (SW + 1)'(SLOT_COUNT);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] N_CNT     = CW'(SLOT_COUNT);
    localparam logic [DCW-1:0] LAST_DIG = DCW'(DIGITS - 1);

    logic [MW-1:0]     mem [SLOT_COUNT];

    qph_in_t           in_reg;
    logic [HASH_W-1:0] key_shift_reg;
    logic [SW-1:0]     rem_reg;
    logic [SW-1:0]     rem_next;
    logic [DCW-1:0]    digit_reg;
    logic [SW-1:0]     slot_reg;
    logic [SW-1:0]     slot_next;
    logic [SW-1:0]     step_reg;
    logic [SW-1:0]     step_next;
    logic [SW-1:0]     eval_slot_reg;
    logic [CW-1:0]     cnt_reg;
    logic [MW-1:0]     rd_reg;
    logic [SW-1:0]     clear_reg;
    qph_out_t          out_reg;
    qph_out_t          out_next;

    logic              rd_used;
    logic [KEY_W-1:0]  rd_key;
    logic [VALUE_W-1:0] rd_val;
    logic [VW-1:0]     red;
    logic [SW:0]       slot_sum;
    logic [SW:0]       step_sum;
    logic [31:0]       slot_wide;
    logic [31:0]       cnt_wide;

    assign rd_used = rd_reg[MW-1];
    assign rd_key  = rd_reg[MW-2 -: KEY_W];
    assign rd_val  = rd_reg[VALUE_W-1:0];

    // remainder of the key, one byte per step by restoring subtraction
    always_comb begin
        red = {rem_reg, key_shift_reg[HASH_W-1 -: DIGIT_W]};
        for (int j = DIGIT_W - 1; j >= 0; j--) begin
            if (red >= (VW'(SLOT_COUNT) << j)) begin
                red = red - (VW'(SLOT_COUNT) << j);
            end
        end
        rem_next = red[SW-1:0];
    end

    // next probe: slot advances by 2i+1, step by 2, both mod slot count
    always_comb begin
        slot_sum  = {1'b0, slot_reg} + {1'b0, step_reg};
        slot_next = (slot_sum >= N_EXT) ? SW'(slot_sum - N_EXT) : slot_sum[SW-1:0];
        step_sum  = {1'b0, step_reg} + (SW + 1)'(2);
        step_next = (step_sum >= N_EXT) ? SW'(step_sum - N_EXT) : step_sum[SW-1:0];
    end

    always_comb begin
        sts.clear_last = (clear_reg == LAST_SLOT);
        sts.hash_last  = (digit_reg == LAST_DIG);
        sts.used       = rd_used;
        sts.match      = (rd_key == in_reg.key);
        sts.exhausted  = (cnt_reg == N_CNT);
        sts.is_lookup  = (in_reg.func == FUNC_LOOKUP);
    end

    always_comb begin
        slot_wide            = 32'(eval_slot_reg);
        cnt_wide             = 32'(cnt_reg);
        out_next.status      = cmd.result;
        out_next.found_value = (cmd.result == STAT_FOUND) ? rd_val : '0;
        out_next.slot_index  = (cmd.result == STAT_FOUND || cmd.result == STAT_INSERTED)
                               ? slot_wide[SLOT_IDX_W-1:0] : '0;
        out_next.probe_count = cnt_wide[PROBE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg <= '0;
        end else if (cmd.clear_step) begin
            clear_reg <= clear_reg + SW'(1);
        end
    end

    // slot memory
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            mem[clear_reg] <= '0;
        end else if (cmd.write_slot) begin
            mem[eval_slot_reg] <= {1'b1, in_reg.key, in_reg.entry_value};
        end
        if (cmd.issue) begin
            rd_reg <= mem[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg        <= s_data;
            key_shift_reg <= {1'b0, s_data.key};
            rem_reg       <= '0;
            digit_reg     <= '0;
        end
        if (cmd.hash_step) begin
            key_shift_reg <= key_shift_reg << DIGIT_W;
            rem_reg       <= rem_next;
            digit_reg     <= digit_reg + DCW'(1);
            if (sts.hash_last) begin
                slot_reg <= rem_next;
                step_reg <= SW'(1);
                cnt_reg  <= '0;
            end
        end
        if (cmd.issue) begin
            eval_slot_reg <= slot_reg;
            slot_reg      <= slot_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_reg + CW'(1);
        end
        if (cmd.load_result) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

// ----- rtl/core/qph_ctrl.sv -----
// ----------------------------------------------------------------------------
// qph_ctrl
// sequencer for clearing, key reduction, probing and result hand-off
// ----------------------------------------------------------------------------
module qph_ctrl import qph_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  qph_sts_t sts,
    output qph_cmd_t cmd
);

    qph_state_t state_reg;
    qph_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        logic        finish;
        qph_status_t result;
        finish         = 1'b0;
        result         = STAT_FULL;
        cmd            = '0;
        cmd.result     = STAT_FULL;
        state_next     = state_reg;
        out_free       = !out_valid_reg || m_ready;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_HASH;
                end
            end
            ST_HASH: begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.issue  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (!sts.used) begin
                    finish = 1'b1;
                    result = sts.is_lookup ? STAT_NOT_FOUND : STAT_INSERTED;
                end else if (sts.is_lookup && sts.match) begin
                    finish = 1'b1;
                    result = STAT_FOUND;
                end else if (sts.exhausted) begin
                    finish = 1'b1;
                    result = sts.is_lookup ? STAT_NOT_FOUND : STAT_FULL;
                end
                if (finish) begin
                    if (out_free) begin
                        cmd.load_result = 1'b1;
                        cmd.result      = result;
                        cmd.write_slot  = (result == STAT_INSERTED);
                        out_valid_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    cmd.issue = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_starts_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_HASH))
        else $error("accepted word did not start key reduction");

    a_result_not_overwritten: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> (!out_valid_reg || m_ready))
        else $error("result register loaded while holding an untaken word");

    a_write_only_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_slot |-> (!sts.used && !sts.is_lookup))
        else $error("slot write on a used slot or a lookup");

    a_no_probe_past_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.issue && state_reg == ST_EVAL) |-> !sts.exhausted)
        else $error("probe issued beyond slot count");

    a_clear_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("result pending during clearing pass");
`endif

endmodule

// ----- rtl/core/quadratic_probe_hash_table.sv -----
// a taken word's key is reduced one byte per cycle, then 1 to SLOT_COUNT probes follow,
// one slot memory read per probe; no new word is taken until the last word's result is loaded
// into the output register
// a finished result waits in the output register while the next word is taken
// reset: synchronous active-low; a clearing pass over all SLOT_COUNT slots follows, s_ready low
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// open-addressed hash table with quadratic probing, insert and lookup
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table import qph_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  qph_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output qph_out_t m_data
);

    qph_cmd_t cmd;
    qph_sts_t sts;

    qph_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    qph_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks inserts and lookups of the quadratic probe hash table against a
// local table model, under sender gaps and receiver back-pressure
// ----------------------------------------------------------------------------
module tb;
    import qph_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 30;
    localparam int SHOW_LIMIT  = 10;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    qph_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    qph_out_t m_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    // table model
    logic                 tbl_used  [SLOTS];
    logic [KEY_W-1:0]     tbl_key   [SLOTS];
    logic [VALUE_W-1:0]   tbl_value [SLOTS];
    logic [KEY_W-1:0]     stored_keys[$];
    qph_out_t             pending_results[$];

    quadratic_probe_hash_table #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic qph_out_t probe_table(qph_in_t w);
        qph_out_t r;
        int home;
        int s;
        logic done;
        r.status      = (w.func == FUNC_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
        r.found_value = '0;
        r.slot_index  = '0;
        r.probe_count = PROBE_W'(SLOTS);
        home = int'({1'b0, w.key} % 64'(SLOTS));
        done = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            s = (home + (i * i) % SLOTS) % SLOTS;
            if (!done) begin
                if (w.func == FUNC_INSERT) begin
                    if (!tbl_used[s]) begin
                        tbl_used[s]   = 1'b1;
                        tbl_key[s]    = w.key;
                        tbl_value[s]  = w.entry_value;
                        stored_keys.push_back(w.key);
                        r.status      = STAT_INSERTED;
                        r.slot_index  = SLOT_IDX_W'(s);
                        r.probe_count = PROBE_W'(i + 1);
                        done = 1'b1;
                    end
                end else if (!tbl_used[s]) begin
                    r.status      = STAT_NOT_FOUND;
                    r.probe_count = PROBE_W'(i + 1);
                    done = 1'b1;
                end else if (tbl_key[s] == w.key) begin
                    r.status      = STAT_FOUND;
                    r.found_value = tbl_value[s];
                    r.slot_index  = SLOT_IDX_W'(s);
                    r.probe_count = PROBE_W'(i + 1);
                    done = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 3))
            0: k = KEY_W'({$urandom, $urandom});
            1: k = KEY_W'($urandom_range(0, 60));
            2: k = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 30));
            default: begin
                if (stored_keys.size() > 0) begin
                    k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                end else begin
                    k = KEY_W'({$urandom, $urandom});
                end
            end
        endcase
        return k;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic qph_in_t make_word(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                          logic [VALUE_W-1:0] v);
        qph_in_t w;
        w.func        = f;
        w.key         = k;
        w.entry_value = v;
        return w;
    endfunction

    task automatic send_word(input qph_in_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(probe_table(w));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (mismatches < SHOW_LIMIT) begin
            $display("mismatch %s: expected %0h got %0h", what, want, got);
        end
        mismatches++;
    endtask

    task automatic check_result(input qph_out_t got);
        qph_out_t want;
        if (pending_results.size() == 0) begin
            note_mismatch("unexpected word", '0, 64'(got));
        end else begin
            want = pending_results.pop_front();
            if (got.status != want.status)
                note_mismatch("status", 64'(want.status), 64'(got.status));
            if (got.found_value != want.found_value)
                note_mismatch("found_value", want.found_value, got.found_value);
            if (got.slot_index != want.slot_index)
                note_mismatch("slot_index", 64'(want.slot_index), 64'(got.slot_index));
            if (got.probe_count != want.probe_count)
                note_mismatch("probe_count", 64'(want.probe_count), 64'(got.probe_count));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_empty_and_extremes();
        send_word(make_word(FUNC_LOOKUP, '0, '1));
        send_word(make_word(FUNC_INSERT, '0, '0));
        send_word(make_word(FUNC_INSERT, '1, '1));
        send_word(make_word(FUNC_LOOKUP, '1, '0));
        send_word(make_word(FUNC_LOOKUP, KEY_W'(2), '0));
    endtask

    task automatic test_duplicate_keys();
        send_word(make_word(FUNC_INSERT, '0, 64'h0123_4567_89ab_cdef));
        send_word(make_word(FUNC_LOOKUP, '0, '1));
        send_word(make_word(FUNC_LOOKUP, KEY_W'(1), '0));
    endtask

    // keys sharing one home slot fill every slot its probe path can reach
    task automatic test_collision_chain();
        for (int j = 0; j < 6; j++) begin
            send_word(make_word(FUNC_INSERT, KEY_W'(5 + SLOTS * j), {$urandom, $urandom}));
        end
        send_word(make_word(FUNC_INSERT, KEY_W'(5 + SLOTS * 6), '1));
        send_word(make_word(FUNC_LOOKUP, KEY_W'(5 + SLOTS * 7), '0));
        send_word(make_word(FUNC_LOOKUP, KEY_W'(5 + SLOTS * 5), '0));
        send_word(make_word(FUNC_LOOKUP, KEY_W'(2 + SLOTS), '0));
        send_word(make_word(FUNC_INSERT, KEY_W'(1), 64'h8000_0000_0000_0001));
        send_word(make_word(FUNC_LOOKUP, KEY_W'(1), '0));
    endtask

    task automatic test_random_traffic(input int words, input int send_pct, input int recv_pct);
        qph_in_t w;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (words) begin
            w.func = ($urandom_range(0, 99) < 35) ? FUNC_INSERT : FUNC_LOOKUP;
            if (w.func == FUNC_LOOKUP && stored_keys.size() > 0 &&
                $urandom_range(0, 99) < 60) begin
                w.key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            end else begin
                w.key = random_key();
            end
            w.entry_value = random_value();
            send_word(w);
        end
    endtask

    task automatic test_drain_pause();
        repeat (6) begin
            send_word(make_word(FUNC_LOOKUP, random_key(), random_value()));
        end
        wait_drained();
        send_word(make_word(FUNC_LOOKUP, random_key(), random_value()));
        wait_drained();
    endtask

    initial begin
        foreach (tbl_used[i]) begin
            tbl_used[i]  = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_and_extremes();
        test_duplicate_keys();
        test_collision_chain();
        wait_drained();

        test_random_traffic(165, 0, 0);
        test_random_traffic(160, 47, 0);
        test_drain_pause();
        test_random_traffic(160, 0, 47);
        test_random_traffic(160, 24, 24);

        wait_drained();
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
